/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mcpa_pkg.sv */
// Package for the motion command priority arbiter: types, codes, constants.
// No dependencies.
package mcpa_pkg;

    localparam logic LQR_ON_BOOT = 1'b0;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        SRC_NONE    = 2'd0,
        SRC_RC      = 2'd1,
        SRC_AI      = 2'd2,
        SRC_CONSOLE = 2'd3
    } src_t;

    typedef enum logic {
        CMD_MOTION = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_AI_ENABLE     = 2'd0,
        REG_RC_ENABLE     = 2'd1,
        REG_AI_TIMEOUT_MS = 2'd2,
        REG_RC_TIMEOUT_MS = 2'd3
    } reg_idx_t;

    localparam logic        AI_ENABLE_RST  = 1'b1;
    localparam logic        RC_ENABLE_RST  = 1'b0;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;

    typedef struct packed {
        logic        ai_enable;
        logic        rc_enable;
        logic [15:0] ai_timeout_ms;
        logic [15:0] rc_timeout_ms;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        src_t               source;
        logic signed [15:0] vx_speed;
        logic signed [15:0] wz_rate;
        logic               brake_req;
        logic               estop_req;
        logic               fault_reset_req;
        logic               lqr_valid_in;
        logic               lqr_enable_in;
        logic [31:0]        time_ms;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] wz;
        logic               brake;
        logic               estop;
        logic               fault_reset;
        logic               lqr;
        src_t               source;
        logic [31:0]        stamp;
    } held_t;

    typedef struct packed {
        held_t cur;
        logic  accepted;
        logic  timed_out;
    } out_word_t;

endpackage

/* hdl/mcpa_if.sv */
// Valid/ready channel interfaces for input and result words.
// No dependencies.
interface mcpa_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [1:0]         source_id;
    logic signed [15:0] vx_speed;
    logic signed [15:0] wz_rate;
    logic               brake_req;
    logic               estop_req;
    logic               fault_reset_req;
    logic               lqr_valid_in;
    logic               lqr_enable_in;
    logic [31:0]        time_ms;

    modport source (
        output valid, cmd, source_id, vx_speed, wz_rate, brake_req, estop_req,
               fault_reset_req, lqr_valid_in, lqr_enable_in, time_ms,
        input  ready
    );
    modport sink (
        input  valid, cmd, source_id, vx_speed, wz_rate, brake_req, estop_req,
               fault_reset_req, lqr_valid_in, lqr_enable_in, time_ms,
        output ready
    );
endinterface

interface mcpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] cur_vx;
    logic signed [15:0] cur_wz;
    logic               cur_brake;
    logic               cur_estop;
    logic               cur_fault_reset;
    logic               cur_lqr_enable;
    logic [1:0]         cur_source;
    logic [31:0]        cur_stamp;
    logic               accepted;
    logic               timed_out;

    modport source (
        output valid, cur_vx, cur_wz, cur_brake, cur_estop, cur_fault_reset,
               cur_lqr_enable, cur_source, cur_stamp, accepted, timed_out,
        input  ready
    );
    modport sink (
        input  valid, cur_vx, cur_wz, cur_brake, cur_estop, cur_fault_reset,
               cur_lqr_enable, cur_source, cur_stamp, accepted, timed_out,
        output ready
    );
endinterface

/* hdl/mcpa_regs.sv */
// APB configuration registers of the arbiter.
// Depends on mcpa_pkg.
module mcpa_regs
    import mcpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_AI_ENABLE:     cfg_next.ai_enable     = pwdata[0];
                REG_RC_ENABLE:     cfg_next.rc_enable     = pwdata[0];
                REG_AI_TIMEOUT_MS: cfg_next.ai_timeout_ms = pwdata[15:0];
                REG_RC_TIMEOUT_MS: cfg_next.rc_timeout_ms = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_AI_ENABLE:     prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.ai_enable};
            REG_RC_ENABLE:     prdata = {{(PDATA_W-1){1'b0}}, cfg_reg.rc_enable};
            REG_AI_TIMEOUT_MS: prdata = {{(PDATA_W-16){1'b0}}, cfg_reg.ai_timeout_ms};
            REG_RC_TIMEOUT_MS: prdata = {{(PDATA_W-16){1'b0}}, cfg_reg.rc_timeout_ms};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ai_enable     <= AI_ENABLE_RST;
            cfg_reg.rc_enable     <= RC_ENABLE_RST;
            cfg_reg.ai_timeout_ms <= TIMEOUT_RST;
            cfg_reg.rc_timeout_ms <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/mcpa_core.sv */
// Arbitration core: held command, per-source stamps, accept and timeout logic.
// Depends on mcpa_pkg.
module mcpa_core
    import mcpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_word_t  item,
    input  logic      advance,
    output out_word_t result
);

    held_t       held_reg;
    held_t       held_next;
    logic [31:0] ai_last_reg;
    logic [31:0] ai_last_next;
    logic [31:0] rc_last_reg;
    logic [31:0] rc_last_next;

    logic        src_disabled;
    logic        outranks;
    logic [31:0] ai_elapsed;
    logic [31:0] rc_elapsed;
    logic        ai_expired;
    logic        rc_expired;
    logic        accepted;
    logic        timed_out;

    assign src_disabled = (item.source == SRC_AI && !cfg.ai_enable) ||
                          (item.source == SRC_RC && !cfg.rc_enable);
    assign outranks     = (item.source >= held_reg.source) || (item.source == SRC_CONSOLE);

    // wrapping elapsed time
    assign ai_elapsed = item.time_ms - ai_last_reg;
    assign rc_elapsed = item.time_ms - rc_last_reg;
    assign ai_expired = (held_reg.source == SRC_AI) &&
                        (ai_elapsed > {16'd0, cfg.ai_timeout_ms});
    assign rc_expired = (held_reg.source == SRC_RC) &&
                        (rc_elapsed > {16'd0, cfg.rc_timeout_ms});

    always_comb
    begin
        held_next    = held_reg;
        ai_last_next = ai_last_reg;
        rc_last_next = rc_last_reg;
        accepted     = 1'b0;
        timed_out    = 1'b0;
        unique case (item.cmd)
            CMD_MOTION:
            begin
                if (item.estop_req)
                begin
                    held_next.vx          = '0;
                    held_next.wz          = '0;
                    held_next.brake       = 1'b1;
                    held_next.estop       = 1'b1;
                    held_next.fault_reset = item.fault_reset_req;
                    held_next.lqr         = item.lqr_enable_in;
                    held_next.source      = item.source;
                    held_next.stamp       = item.time_ms;
                    accepted              = 1'b1;
                end
                else if (!src_disabled && outranks)
                begin
                    held_next.vx          = item.vx_speed;
                    held_next.wz          = item.wz_rate;
                    held_next.brake       = item.brake_req;
                    held_next.estop       = 1'b0;
                    held_next.fault_reset = item.fault_reset_req;
                    held_next.source      = item.source;
                    held_next.stamp       = item.time_ms;
                    if (item.lqr_valid_in)
                    begin
                        held_next.lqr = item.lqr_enable_in;
                    end
                    if (item.source == SRC_AI)
                    begin
                        ai_last_next = item.time_ms;
                    end
                    if (item.source == SRC_RC)
                    begin
                        rc_last_next = item.time_ms;
                    end
                    accepted = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (ai_expired || rc_expired)
                begin
                    held_next.vx     = '0;
                    held_next.wz     = '0;
                    held_next.brake  = 1'b1;
                    held_next.source = SRC_NONE;
                    timed_out        = 1'b1;
                end
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    assign result.cur       = held_next;
    assign result.accepted  = accepted;
    assign result.timed_out = timed_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg.vx          <= '0;
            held_reg.wz          <= '0;
            held_reg.brake       <= 1'b0;
            held_reg.estop       <= 1'b0;
            held_reg.fault_reset <= 1'b0;
            held_reg.lqr         <= LQR_ON_BOOT;
            held_reg.source      <= SRC_NONE;
            held_reg.stamp       <= '0;
            ai_last_reg          <= '0;
            rc_last_reg          <= '0;
        end
        else if (advance)
        begin
            held_reg    <= held_next;
            ai_last_reg <= ai_last_next;
            rc_last_reg <= rc_last_next;
        end
    end

endmodule

/* hdl/motion_command_priority_arbiter.sv */
// Motion command priority arbiter, top level.
// Throughput: one word per cycle; input register, one pass of arbitration
// logic, result register. Stalls only when the result register is held.
// Reset (rst_n low, asynchronous): pipeline empty, no command held, source
// none, registers at their reset values.
`include "assert_macros.svh"

module motion_command_priority_arbiter
    import mcpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mcpa_in_if.sink            in_ch,
    mcpa_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    in_word_t  in_word;
    in_word_t  s1_word_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    out_word_t result;
    out_word_t out_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      advance;
    logic      in_take;

    mcpa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcpa_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (s1_word_reg),
        .advance (advance),
        .result  (result)
    );

    assign in_word.cmd             = cmd_t'(in_ch.cmd);
    assign in_word.source          = src_t'(in_ch.source_id);
    assign in_word.vx_speed        = in_ch.vx_speed;
    assign in_word.wz_rate         = in_ch.wz_rate;
    assign in_word.brake_req       = in_ch.brake_req;
    assign in_word.estop_req       = in_ch.estop_req;
    assign in_word.fault_reset_req = in_ch.fault_reset_req;
    assign in_word.lqr_valid_in    = in_ch.lqr_valid_in;
    assign in_word.lqr_enable_in   = in_ch.lqr_enable_in;
    assign in_word.time_ms         = in_ch.time_ms;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_word_reg <= in_word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.cur_vx          = out_word_reg.cur.vx;
    assign out_ch.cur_wz          = out_word_reg.cur.wz;
    assign out_ch.cur_brake       = out_word_reg.cur.brake;
    assign out_ch.cur_estop       = out_word_reg.cur.estop;
    assign out_ch.cur_fault_reset = out_word_reg.cur.fault_reset;
    assign out_ch.cur_lqr_enable  = out_word_reg.cur.lqr;
    assign out_ch.cur_source      = out_word_reg.cur.source;
    assign out_ch.cur_stamp       = out_word_reg.cur.stamp;
    assign out_ch.accepted        = out_word_reg.accepted;
    assign out_ch.timed_out       = out_word_reg.timed_out;

    `ASSERT_IMPL(a_flags_exclusive, clk, rst_n, out_valid_reg, !(out_word_reg.accepted && out_word_reg.timed_out), "accepted and timed_out both set")
    `ASSERT_IMPL(a_timeout_stops, clk, rst_n, out_valid_reg && out_word_reg.timed_out, out_word_reg.cur.brake && out_word_reg.cur.vx == '0 && out_word_reg.cur.wz == '0 && out_word_reg.cur.source == SRC_NONE, "timeout did not force a stop")
    `ASSERT_IMPL(a_estop_braked, clk, rst_n, out_valid_reg && out_word_reg.cur.estop, out_word_reg.cur.brake && out_word_reg.cur.vx == '0 && out_word_reg.cur.wz == '0, "estop held without brake and zero speed")
    `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg, "stalled word lost from input register")

endmodule

/* sim/mcpa_status_monitor.sv */
`timescale 1ns / 1ps
// Status monitor for the motion command priority arbiter: follows register writes,
// predicts the status word for each accepted input word and compares results.
// Depends on mcpa_pkg and the channel interfaces in mcpa_if.
module mcpa_status_monitor
    import mcpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mcpa_in_if                 in_ch,
    mcpa_out_if                out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 words_in_flight,
    output int                 words_checked,
    output int                 words_taken,
    output int                 stops_forced
);

    cfg_t        regs;
    held_t       cmd;
    logic [31:0] ai_seen;
    logic [31:0] rc_seen;
    out_word_t   status_q[$];

    task automatic arbitrate(input in_word_t w, output out_word_t r);
        logic        taken;
        logic        stopped;
        logic        blocked;
        logic [31:0] ai_gap;
        logic [31:0] rc_gap;
        taken   = 1'b0;
        stopped = 1'b0;
        blocked = (w.source == SRC_AI && !regs.ai_enable) ||
                  (w.source == SRC_RC && !regs.rc_enable);
        ai_gap  = w.time_ms - ai_seen;
        rc_gap  = w.time_ms - rc_seen;
        if (w.cmd == CMD_MOTION) begin
            if (w.estop_req) begin
                cmd.vx          = '0;
                cmd.wz          = '0;
                cmd.brake       = 1'b1;
                cmd.estop       = 1'b1;
                cmd.fault_reset = w.fault_reset_req;
                cmd.lqr         = w.lqr_enable_in;
                cmd.source      = w.source;
                cmd.stamp       = w.time_ms;
                taken           = 1'b1;
            end
            else if (!blocked && (w.source >= cmd.source || w.source == SRC_CONSOLE)) begin
                cmd.vx          = w.vx_speed;
                cmd.wz          = w.wz_rate;
                cmd.brake       = w.brake_req;
                cmd.estop       = 1'b0;
                cmd.fault_reset = w.fault_reset_req;
                cmd.source      = w.source;
                cmd.stamp       = w.time_ms;
                if (w.lqr_valid_in)
                    cmd.lqr = w.lqr_enable_in;
                if (w.source == SRC_AI)
                    ai_seen = w.time_ms;
                if (w.source == SRC_RC)
                    rc_seen = w.time_ms;
                taken = 1'b1;
            end
        end
        else if ((cmd.source == SRC_AI && ai_gap > {16'd0, regs.ai_timeout_ms}) ||
                 (cmd.source == SRC_RC && rc_gap > {16'd0, regs.rc_timeout_ms})) begin
            cmd.vx     = '0;
            cmd.wz     = '0;
            cmd.brake  = 1'b1;
            cmd.source = SRC_NONE;
            stopped    = 1'b1;
        end
        r.cur       = cmd;
        r.accepted  = taken;
        r.timed_out = stopped;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        in_word_t  w;
        out_word_t want;
        out_word_t next;
        if (!rst_n) begin
            regs.ai_enable     = AI_ENABLE_RST;
            regs.rc_enable     = RC_ENABLE_RST;
            regs.ai_timeout_ms = TIMEOUT_RST;
            regs.rc_timeout_ms = TIMEOUT_RST;
            cmd                = '0;
            cmd.lqr            = LQR_ON_BOOT;
            cmd.source         = SRC_NONE;
            ai_seen            = '0;
            rc_seen            = '0;
            status_q.delete();
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    $error("status word with nothing outstanding");
                    fail_count++;
                end
                else begin
                    want = status_q.pop_front();
                    check_field("cur_vx", want.cur.vx, out_ch.cur_vx);
                    check_field("cur_wz", want.cur.wz, out_ch.cur_wz);
                    check_field("cur_brake", want.cur.brake, out_ch.cur_brake);
                    check_field("cur_estop", want.cur.estop, out_ch.cur_estop);
                    check_field("cur_fault_reset", want.cur.fault_reset,
                                out_ch.cur_fault_reset);
                    check_field("cur_lqr_enable", want.cur.lqr, out_ch.cur_lqr_enable);
                    check_field("cur_source", want.cur.source, out_ch.cur_source);
                    check_field("cur_stamp", want.cur.stamp, out_ch.cur_stamp);
                    check_field("accepted", want.accepted, out_ch.accepted);
                    check_field("timed_out", want.timed_out, out_ch.timed_out);
                end
                words_checked++;
                if (out_ch.accepted === 1'b1)
                    words_taken++;
                if (out_ch.timed_out === 1'b1)
                    stops_forced++;
            end
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_AI_ENABLE:     regs.ai_enable     = pwdata[0];
                    REG_RC_ENABLE:     regs.rc_enable     = pwdata[0];
                    REG_AI_TIMEOUT_MS: regs.ai_timeout_ms = pwdata[15:0];
                    REG_RC_TIMEOUT_MS: regs.rc_timeout_ms = pwdata[15:0];
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                w.cmd             = cmd_t'(in_ch.cmd);
                w.source          = src_t'(in_ch.source_id);
                w.vx_speed        = in_ch.vx_speed;
                w.wz_rate         = in_ch.wz_rate;
                w.brake_req       = in_ch.brake_req;
                w.estop_req       = in_ch.estop_req;
                w.fault_reset_req = in_ch.fault_reset_req;
                w.lqr_valid_in    = in_ch.lqr_valid_in;
                w.lqr_enable_in   = in_ch.lqr_enable_in;
                w.time_ms         = in_ch.time_ms;
                arbitrate(w, next);
                status_q.push_back(next);
            end
        end
        words_in_flight = status_q.size();
    end

endmodule

/* sim/motion_command_priority_arbiter_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the motion command priority arbiter: clock, reset, register
// writes, directed and random words, verdict. Depends on mcpa_pkg, mcpa_if,
// mcpa_status_monitor and the arbiter RTL.
module motion_command_priority_arbiter_tb;
    import mcpa_pkg::*;

    localparam int RANDOM_WORDS = 1600;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int words_in_flight;
    int words_checked;
    int words_taken;
    int stops_forced;
    int cycles;
    int idle_pct;
    int stall_pct;
    int settings;

    logic [31:0] now_ms;
    logic [31:0] ai_sent;
    logic [31:0] rc_sent;
    logic [15:0] ai_limit;
    logic [15:0] rc_limit;

    mcpa_in_if  in_ch();
    mcpa_out_if out_ch();

    motion_command_priority_arbiter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mcpa_status_monitor status_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight),
        .words_checked   (words_checked),
        .words_taken     (words_taken),
        .stops_forced    (stops_forced)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_word(input in_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.cmd             <= w.cmd;
        in_ch.source_id       <= w.source;
        in_ch.vx_speed        <= w.vx_speed;
        in_ch.wz_rate         <= w.wz_rate;
        in_ch.brake_req       <= w.brake_req;
        in_ch.estop_req       <= w.estop_req;
        in_ch.fault_reset_req <= w.fault_reset_req;
        in_ch.lqr_valid_in    <= w.lqr_valid_in;
        in_ch.lqr_enable_in   <= w.lqr_enable_in;
        in_ch.time_ms         <= w.time_ms;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // hold valid low until every status word is back
    task automatic drain;
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (words_in_flight != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic ai_en, input logic rc_en,
                              input logic [15:0] ai_to, input logic [15:0] rc_to);
        write_reg(REG_AI_ENABLE, {15'd0, ai_en});
        write_reg(REG_RC_ENABLE, {15'd0, rc_en});
        write_reg(REG_AI_TIMEOUT_MS, ai_to);
        write_reg(REG_RC_TIMEOUT_MS, rc_to);
        ai_limit = ai_to;
        rc_limit = rc_to;
        settings++;
    endtask

    task automatic motion(input src_t src, input logic [15:0] vx, input logic [15:0] wz,
                          input logic brake, input logic estop, input logic clr,
                          input logic lqr_v, input logic lqr_e, input logic [31:0] t);
        in_word_t w;
        w.cmd             = CMD_MOTION;
        w.source          = src;
        w.vx_speed        = vx;
        w.wz_rate         = wz;
        w.brake_req       = brake;
        w.estop_req       = estop;
        w.fault_reset_req = clr;
        w.lqr_valid_in    = lqr_v;
        w.lqr_enable_in   = lqr_e;
        w.time_ms         = t;
        send_word(w);
    endtask

    task automatic tick(input logic [31:0] t);
        in_word_t w;
        w         = '0;
        w.cmd     = CMD_TICK;
        w.time_ms = t;
        send_word(w);
    endtask

    // mostly plausible traffic: rising stamps, ticks near the timeout edges,
    // a share of fully random words
    function automatic in_word_t random_word();
        in_word_t    w;
        logic [95:0] bits;
        int          pick;
        int          src_pick;
        bits = {$urandom, $urandom, $urandom};
        w    = bits[71:0];
        pick = $urandom_range(99);
        if (pick >= 15 && pick < 45)
        begin
            w.cmd = CMD_TICK;
            case ($urandom_range(2))
                0:       w.time_ms = ai_sent + ai_limit + $urandom_range(4) - 2;
                1:       w.time_ms = rc_sent + rc_limit + $urandom_range(4) - 2;
                default: w.time_ms = now_ms + $urandom_range(8);
            endcase
        end
        else if (pick >= 45)
        begin
            w.cmd    = CMD_MOTION;
            src_pick = $urandom_range(99);
            if (src_pick < 12)
                w.source = SRC_NONE;
            else if (src_pick < 47)
                w.source = SRC_RC;
            else if (src_pick < 92)
                w.source = SRC_AI;
            else
                w.source = SRC_CONSOLE;
            w.estop_req = ($urandom_range(99) < 6);
            if ($urandom_range(9) == 0)
                w.vx_speed = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            if ($urandom_range(9) == 0)
                w.wz_rate = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            now_ms    = now_ms + $urandom_range(3);
            w.time_ms = now_ms;
            if (w.source == SRC_AI)
                ai_sent = now_ms;
            if (w.source == SRC_RC)
                rc_sent = now_ms;
        end
        return w;
    endfunction

    initial
    begin
        int p;
        int i;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.cmd             = 1'b0;
        in_ch.source_id       = '0;
        in_ch.vx_speed        = '0;
        in_ch.wz_rate         = '0;
        in_ch.brake_req       = 1'b0;
        in_ch.estop_req       = 1'b0;
        in_ch.fault_reset_req = 1'b0;
        in_ch.lqr_valid_in    = 1'b0;
        in_ch.lqr_enable_in   = 1'b0;
        in_ch.time_ms         = '0;
        out_ch.ready          = 1'b0;
        idle_pct              = 0;
        stall_pct             = 0;
        settings              = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: ai on, rc off, both timeouts 500
        tick(32'd0);
        motion(SRC_NONE, 16'h0100, 16'h0000, 0, 0, 0, 0, 1, 32'd5);
        motion(SRC_RC, 16'h0001, 16'h0001, 0, 0, 0, 1, 1, 32'd10);
        motion(SRC_RC, 16'h7FFF, 16'h1111, 0, 1, 1, 0, 1, 32'd11);
        tick(32'd611);
        motion(SRC_AI, 16'h7FFF, 16'h8000, 1, 0, 1, 1, 0, 32'hFFFF_FF00);
        motion(SRC_NONE, 16'h2222, 16'h3333, 0, 0, 0, 1, 1, 32'hFFFF_FF01);
        tick(32'h0000_00F4);
        tick(32'h0000_00F5);
        motion(SRC_CONSOLE, 16'h8000, 16'h7FFF, 0, 0, 1, 1, 1, 32'hFFFF_FFFF);
        motion(SRC_AI, 16'h0055, 16'h00AA, 1, 0, 0, 1, 0, 32'h0000_0100);
        tick(32'h0001_869F);
        motion(SRC_CONSOLE, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0, 32'h0001_86A0);
        motion(SRC_NONE, 16'h1234, 16'h4321, 0, 1, 0, 0, 0, 32'h8000_0000);
        motion(SRC_NONE, 16'h5A5A, 16'hA5A5, 1, 0, 1, 1, 0, 32'h8000_0001);

        // ai off, rc on, timeouts at both extremes
        drain();
        set_config(1'b0, 1'b1, 16'd0, 16'hFFFF);
        motion(SRC_AI, 16'h0101, 16'h0202, 0, 0, 0, 0, 0, 32'd1);
        motion(SRC_AI, 16'h0303, 16'h0404, 0, 1, 0, 1, 1, 32'd2);
        tick(32'd3);
        motion(SRC_RC, 16'h1234, 16'hFEDC, 0, 0, 0, 1, 0, 32'd1000);
        tick(32'd1000 + 32'd65535);
        tick(32'd1000 + 32'd65536);
        motion(SRC_RC, 16'h0F0F, 16'hF0F0, 1, 0, 1, 0, 0, 32'd70000);

        drain();
        write_reg(REG_AI_ENABLE, 16'd1);
        motion(SRC_AI, 16'h7FFF, 16'h8000, 0, 0, 0, 1, 1, 32'h7FFF_FFFF);
        tick(32'h7FFF_FFFF);
        tick(32'h8000_0000);

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:
                begin
                    set_config(1'b1, 1'b1, 16'd20, 16'd30);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    set_config(1'b1, 1'b1, 16'd0, 16'hFFFF);
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    set_config(1'b0, 1'b1, 16'd5, 16'd1);
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                3:
                begin
                    set_config(1'b1, 1'b0, 16'hFFFF, 16'd0);
                    idle_pct  = 12;
                    stall_pct = 12;
                end
                4:
                begin
                    set_config(1'b1, 1'b1, 16'($urandom_range(60)), 16'($urandom_range(60)));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                5:
                begin
                    set_config(1'b0, 1'b0, 16'd7, 16'd9);
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                6:
                begin
                    set_config(1'b1, 1'b1, 16'd3, 16'd3);
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    set_config(1'b1, 1'b1, 16'($urandom), 16'($urandom));
                    idle_pct  = 12;
                    stall_pct = 12;
                end
            endcase
            now_ms  = $urandom;
            ai_sent = now_ms;
            rc_sent = now_ms;
            for (i = 0; i < RANDOM_WORDS / PHASES; i++)
            begin
                if (i == RANDOM_WORDS / PHASES / 2)
                    drain();
                send_word(random_word());
            end
        end

        drain();
        repeat (10) @(negedge clk);
        $display("Checked %0d status words under %0d register settings: %0d commands taken, %0d forced stops on timeout.",
                 words_checked, settings, words_taken, stops_forced);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
